>>> design/rvp_pkg.sv
// Package for the RTP video packetizer.
// Beat types, the front-to-back command, register indexes and header constants.
// No dependencies.
package rvp_pkg;

  localparam int DEFAULT_MAX_PACKET = 2048;
  localparam int MIN_MTU            = 15;
  localparam int RTP_HDR_LEN        = 12;
  localparam int RESET_MTU          = 1200;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [4:0] FU_A_TYPE        = 5'd28;
  localparam logic [7:0] AV1_SINGLE       = 8'h10;
  localparam logic [7:0] AV1_FIRST        = 8'h50;
  localparam logic [7:0] AV1_MIDDLE       = 8'hD0;
  localparam logic [7:0] AV1_LAST         = 8'h90;
  localparam logic [7:0] AV1_N_BIT        = 8'h08;
  localparam logic [3:0] AV1_OBU_SEQ_HDR  = 4'd1;

  localparam logic [1:0] NHDR_NONE = 2'd0;
  localparam logic [1:0] NHDR_AV1  = 2'd1;
  localparam logic [1:0] NHDR_FU_A = 2'd2;

  typedef enum logic [7:0] {
    REG_SSRC         = 8'd0,
    REG_PAYLOAD_TYPE = 8'd1,
    REG_MAX_PACKET   = 8'd2,
    REG_CODEC_MODE   = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  unit_byte;
    logic [15:0] unit_length;
    logic        last_unit;
    logic [31:0] timestamp;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
    logic       packet_marker;
    logic       run_last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        pkt_end;
    logic        marker;
    logic        new_pkt;
    logic [1:0]  nhdr;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [6:0]  pt;
  } cmd_t;

endpackage

>>> design/rvp_front.sv
// Front end: configuration registers, unit/packet bookkeeping, per-byte command.
// Depends on rvp_pkg.
module rvp_front import rvp_pkg::*; #(
  parameter int MAX_PACKET = DEFAULT_MAX_PACKET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        unit_valid,
  output logic        unit_ready,
  input  in_beat_t    unit,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int          FILL_W = $clog2(MAX_PACKET);
  localparam logic [15:0] MaxPkt = 16'(MAX_PACKET);

  logic [31:0] ssrc;
  logic [6:0]  pt;
  logic [11:0] mtu_reg;
  logic        mode;

  logic [15:0]       seq;
  logic [15:0]       upos;
  logic [FILL_W-1:0] fill;
  logic [7:0]        unit_header;

  logic [15:0]       mtu_sat, room, cap, len1, pos, remaining, pos_inc;
  logic [FILL_W-1:0] fill0, fill1;
  logic [7:0]        hdr_eff;
  logic              frag264, drop, lastpkt, mk, new_pkt, pkt_end, unit_done, av1_n;
  logic [1:0]        nhdr;
  logic [7:0]        h0, h1;
  logic              accept;

  assign cfg_ready  = 1'b1;
  assign unit_ready = !q_full;
  assign accept     = unit_valid && unit_ready;

  always_comb begin
    mtu_sat = 16'(mtu_reg);
    if (mtu_sat > MaxPkt) mtu_sat = MaxPkt;
    if (mtu_sat < 16'(MIN_MTU)) mtu_sat = 16'(MIN_MTU);
    room = mtu_sat - 16'(RTP_HDR_LEN);

    len1 = (unit.unit_length == 16'd0) ? 16'd1 : unit.unit_length;
    if (upos >= len1) begin
      pos   = 16'd0;
      fill0 = '0;
    end else begin
      pos   = upos;
      fill0 = fill;
    end
    hdr_eff = (pos == 16'd0) ? unit.unit_byte : unit_header;

    frag264 = !mode && (len1 > room);
    drop    = frag264 && (pos == 16'd0);
    if (!mode) begin
      cap  = frag264 ? room - 16'd2 : room;
      nhdr = frag264 ? NHDR_FU_A : NHDR_NONE;
    end else begin
      cap  = room - 16'd1;
      nhdr = NHDR_AV1;
    end
    fill1 = (16'(fill0) >= cap) ? '0 : fill0;

    remaining = len1 - pos;
    lastpkt   = remaining <= (cap - 16'(fill1));
    mk        = unit.last_unit && lastpkt;
    new_pkt   = (fill1 == '0);

    av1_n = (hdr_eff[6:3] == AV1_OBU_SEQ_HDR);
    h0 = '0;
    h1 = '0;
    if (!mode) begin
      h0 = {hdr_eff[7], hdr_eff[6:5], FU_A_TYPE};
      h1 = {pos == 16'd1, lastpkt, 1'b0, hdr_eff[4:0]};
    end else if (len1 <= room - 16'd1) begin
      h0 = AV1_SINGLE | (av1_n ? AV1_N_BIT : 8'h00);
    end else if (pos == 16'd0) begin
      h0 = AV1_FIRST | (av1_n ? AV1_N_BIT : 8'h00);
    end else if (!lastpkt) begin
      h0 = AV1_MIDDLE;
    end else begin
      h0 = AV1_LAST;
    end

    pkt_end   = (16'(fill1) + 16'd1 >= cap) || (remaining == 16'd1);
    pos_inc   = pos + 16'd1;
    unit_done = pos_inc >= len1;
  end

  assign q_push = accept && !drop;

  always_comb begin
    q_cmd.data_byte = unit.unit_byte;
    q_cmd.pkt_end   = pkt_end;
    q_cmd.marker    = mk;
    q_cmd.new_pkt   = new_pkt;
    q_cmd.nhdr      = nhdr;
    q_cmd.h0        = h0;
    q_cmd.h1        = h1;
    q_cmd.seq       = seq;
    q_cmd.ts        = unit.timestamp;
    q_cmd.ssrc      = ssrc;
    q_cmd.pt        = pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ssrc        <= '0;
      pt          <= '0;
      mtu_reg     <= 12'(RESET_MTU);
      mode        <= 1'b0;
      seq         <= '0;
      upos        <= '0;
      fill        <= '0;
      unit_header <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SSRC:         ssrc    <= cfg_data;
          REG_PAYLOAD_TYPE: pt      <= cfg_data[6:0];
          REG_MAX_PACKET:   mtu_reg <= cfg_data[11:0];
          REG_CODEC_MODE:   mode    <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (pos == 16'd0) unit_header <= unit.unit_byte;
        if (drop) begin
          upos <= 16'd1;
          fill <= '0;
        end else begin
          if (new_pkt) seq <= seq + 16'd1;
          if (unit_done) begin
            upos <= '0;
            fill <= '0;
          end else begin
            upos <= pos_inc;
            fill <= pkt_end ? '0 : fill1 + FILL_W'(1);
          end
        end
      end
    end
  end

endmodule

>>> design/rvp_queue.sv
// Two-entry command queue between front and back ends.
// Depends on rvp_pkg.
module rvp_queue import rvp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/rvp_back.sv
// Back end: expands each command into its data beat, preceded on a new packet
// by the RTP header and any payload header. Depends on rvp_pkg.
module rvp_back import rvp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      packet_valid,
  input  logic      packet_ready,
  output out_beat_t packet
);

  logic [3:0] cnt;
  logic [3:0] total;
  logic       last_step, advance;
  logic [7:0] hdr_byte;

  assign total     = head_cmd.new_pkt ? 4'd13 + 4'(head_cmd.nhdr) : 4'd1;
  assign last_step = (cnt == total - 4'd1);
  assign advance   = head_valid && (!packet_valid || packet_ready);
  assign pop       = advance && last_step;

  always_comb begin
    case (cnt)
      4'd0:    hdr_byte = RTP_VERSION_BYTE;
      4'd1:    hdr_byte = {head_cmd.marker, head_cmd.pt};
      4'd2:    hdr_byte = head_cmd.seq[15:8];
      4'd3:    hdr_byte = head_cmd.seq[7:0];
      4'd4:    hdr_byte = head_cmd.ts[31:24];
      4'd5:    hdr_byte = head_cmd.ts[23:16];
      4'd6:    hdr_byte = head_cmd.ts[15:8];
      4'd7:    hdr_byte = head_cmd.ts[7:0];
      4'd8:    hdr_byte = head_cmd.ssrc[31:24];
      4'd9:    hdr_byte = head_cmd.ssrc[23:16];
      4'd10:   hdr_byte = head_cmd.ssrc[15:8];
      4'd11:   hdr_byte = head_cmd.ssrc[7:0];
      4'd12:   hdr_byte = head_cmd.h0;
      4'd13:   hdr_byte = head_cmd.h1;
      default: hdr_byte = head_cmd.data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      packet_valid <= 1'b0;
    end else begin
      if (advance) begin
        packet_valid         <= 1'b1;
        packet.packet_byte   <= last_step ? head_cmd.data_byte : hdr_byte;
        packet.packet_end    <= last_step && head_cmd.pkt_end;
        packet.packet_marker <= head_cmd.marker;
        packet.run_last      <= last_step;
        cnt                  <= last_step ? 4'd0 : cnt + 4'd1;
      end else if (packet_ready) begin
        packet_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/rtp_video_packetizer.sv
// RTP video packetizer top level (H.264 FU-A / AV1 aggregation header).
// Depends on rvp_pkg, rvp_front, rvp_queue, rvp_back.
//
// Usage: unit bytes arrive on unit_valid/unit_ready, one beat per byte with
// the unit length, last-unit flag and timestamp. RTP packet bytes leave on
// packet_valid/packet_ready, one beat per byte, with end, marker and a flag
// on the last beat caused by each input byte. Registers are written on
// cfg_valid/cfg_ready (always ready) by index: SSRC, payload type, MTU, mode.
// The queue registers an accepted byte's command; the back end registers its
// output beats. Throughput: one output beat per cycle while a command is queued
// and the receiver is ready; a packet-opening byte gives 13 to 15 beats (header
// plus data), others give one. The front end takes one byte per cycle while its
// two-entry command queue has room; the H.264 NAL header byte of a fragmented
// unit yields no beat. Reset clears sequence number, unit position, queue and
// output stage; the registers reset to zero except the MTU, which resets to 1200.
// A stalled receiver holds the output beat; the queue fills and then
// unit_ready drops until the back end drains.
module rtp_video_packetizer import rvp_pkg::*; #(
  parameter int MAX_PACKET = DEFAULT_MAX_PACKET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        unit_valid,
  output logic        unit_ready,
  input  in_beat_t    unit,
  output logic        packet_valid,
  input  logic        packet_ready,
  output out_beat_t   packet
);

  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_cmd, q_head;

  rvp_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit       (unit),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  rvp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  rvp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head_cmd     (q_head),
    .pop          (q_pop),
    .packet_valid (packet_valid),
    .packet_ready (packet_ready),
    .packet       (packet)
  );

endmodule
